@@ hdl/dtst_pkg.sv @@
// ----------------------------------------------------------------------------
// dtst_pkg
// Types and constants shared by the deadline task slot table.
// ----------------------------------------------------------------------------
package dtst_pkg;

    localparam int DEF_SLOTS  = 16;
    localparam int MAX_FIRE   = 16;
    localparam int FIRE_W     = $clog2(MAX_FIRE + 1);
    localparam int NOW_W      = 32;
    localparam int DELAY_W    = 16;
    localparam int CODE_W     = 4;
    localparam int PARAM_W    = 16;
    localparam int SLOT_OUT_W = 4;
    localparam int KIND_W     = 2;

    localparam logic CMD_ADD  = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    localparam logic [KIND_W-1:0] KIND_FIRED    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ACCEPTED = 2'd1;
    localparam logic [KIND_W-1:0] KIND_REJECTED = 2'd2;
    localparam logic [KIND_W-1:0] KIND_NONE     = 2'd3;

    localparam logic [CODE_W-1:0] CODE_EMPTY = '0;

    typedef struct packed {
        logic                      cmd;
        logic [DELAY_W-1:0]        delay_ms;
        logic [CODE_W-1:0]         task_code;
        logic signed [PARAM_W-1:0] task_param;
    } t_in_word;

    typedef struct packed {
        logic [KIND_W-1:0]         kind;
        logic [CODE_W-1:0]         fired_code;
        logic signed [PARAM_W-1:0] fired_param;
        logic [SLOT_OUT_W-1:0]     slot_index;
        logic                      last;
    } t_out_word;

    typedef struct packed {
        logic [CODE_W-1:0]         code;
        logic [NOW_W-1:0]          deadline;
        logic signed [PARAM_W-1:0] value;
    } t_slot_entry;

endpackage

@@ hdl/deadline_task_slot_table_top.sv @@
// ----------------------------------------------------------------------------
// deadline_task_slot_table_top
// Timed task slot table with a millisecond counter. Add stores a task in
// the lowest free slot; tick advances the counter and fires due slots, up to MAX_FIRE.
//
//   channel | direction | handshake                   | word
//   --------+-----------+-----------------------------+-----------
//   in      | input     | i_in_valid / o_in_stall     | t_in_word
//   out     | output    | o_out_valid / i_out_stall   | t_out_word
//
// One item at a time. An add scans occupancy one slot a cycle. A tick
// reads the slot memory one slot a cycle through a registered read,
// and holds the scan while a fired word cannot go to a stalled output.
// Synchronous active-low reset empties all slots and clears the counter.
// Input is stalled until the last word of the item is in the output
// register.
// ----------------------------------------------------------------------------
module deadline_task_slot_table_top #(
    parameter int SLOTS = dtst_pkg::DEF_SLOTS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  dtst_pkg::t_in_word  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output dtst_pkg::t_out_word o_out_data
);
    import dtst_pkg::*;

    localparam int IDX_W = $clog2(SLOTS);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(SLOTS - 1);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_ADD   = 2'd1;
    localparam logic [1:0] ST_TICK  = 2'd2;
    localparam logic [1:0] ST_FLUSH = 2'd3;

    logic [1:0]        r_state, n_state;
    logic [NOW_W-1:0]  r_now, n_now;
    logic [SLOTS-1:0]  r_occ, n_occ;
    logic [IDX_W-1:0]  r_rd_idx, n_rd_idx;
    logic              r_rd_on, n_rd_on;
    logic              r_cmp_vld, n_cmp_vld;
    logic [IDX_W-1:0]  r_cmp_idx, n_cmp_idx;
    logic [FIRE_W-1:0] r_fire_cnt, n_fire_cnt;
    t_out_word         r_held, n_held;
    logic              r_held_vld, n_held_vld;
    logic              r_out_vld, n_out_vld;
    t_out_word         r_out, n_out;
    logic [DELAY_W-1:0]        r_delay, n_delay;
    logic [CODE_W-1:0]         r_code, n_code;
    logic signed [PARAM_W-1:0] r_param, n_param;

    logic        wr_en;
    t_slot_entry wr_data;
    logic        rd_en;
    t_slot_entry rd_data;
    logic        can_push;
    logic        cmp_due;
    logic        freeze;
    t_out_word   fired_word;

    dtst_store #(
        .SLOTS (SLOTS)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_idx  (r_rd_idx),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_idx  (r_rd_idx),
        .o_rd_data (rd_data)
    );

    assign can_push = !r_out_vld || !i_out_stall;
    assign cmp_due  = r_cmp_vld && r_occ[r_cmp_idx] && (rd_data.deadline <= r_now);
    assign freeze   = cmp_due && r_held_vld && !can_push;

    assign wr_data.code     = r_code;
    assign wr_data.deadline = r_now + NOW_W'(r_delay);
    assign wr_data.value    = r_param;

    always_comb begin
        fired_word.kind        = KIND_FIRED;
        fired_word.fired_code  = rd_data.code;
        fired_word.fired_param = rd_data.value;
        fired_word.slot_index  = SLOT_OUT_W'(r_cmp_idx);
        fired_word.last        = 1'b0;
    end

    always_comb begin
        n_state    = r_state;
        n_now      = r_now;
        n_occ      = r_occ;
        n_rd_idx   = r_rd_idx;
        n_rd_on    = r_rd_on;
        n_cmp_vld  = r_cmp_vld;
        n_cmp_idx  = r_cmp_idx;
        n_fire_cnt = r_fire_cnt;
        n_held     = r_held;
        n_held_vld = r_held_vld;
        n_delay    = r_delay;
        n_code     = r_code;
        n_param    = r_param;
        n_out      = r_out;
        n_out_vld  = r_out_vld && i_out_stall;
        wr_en      = 1'b0;
        rd_en      = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_held.kind        = KIND_REJECTED;
                    n_held.fired_code  = CODE_EMPTY;
                    n_held.fired_param = '0;
                    n_held.slot_index  = '0;
                    n_held.last        = 1'b1;
                    n_held_vld         = 1'b0;
                    n_rd_idx           = '0;
                    n_rd_on            = 1'b1;
                    n_cmp_vld          = 1'b0;
                    n_fire_cnt         = '0;
                    n_delay            = i_in_data.delay_ms;
                    n_code             = i_in_data.task_code;
                    n_param            = i_in_data.task_param;
                    if (i_in_data.cmd == CMD_TICK) begin
                        n_held.kind = KIND_NONE;
                        n_now       = r_now + NOW_W'(1);
                        n_state     = ST_TICK;
                    end else if (i_in_data.task_code == CODE_EMPTY) begin
                        n_state = ST_FLUSH;
                    end else begin
                        n_state = ST_ADD;
                    end
                end
            end
            ST_ADD: begin
                if (!r_occ[r_rd_idx]) begin
                    wr_en              = 1'b1;
                    n_occ[r_rd_idx]    = 1'b1;
                    n_held.kind        = KIND_ACCEPTED;
                    n_held.fired_code  = r_code;
                    n_held.fired_param = r_param;
                    n_held.slot_index  = SLOT_OUT_W'(r_rd_idx);
                    n_state            = ST_FLUSH;
                end else if (r_rd_idx == IDX_LAST) begin
                    n_state = ST_FLUSH;
                end else begin
                    n_rd_idx = r_rd_idx + IDX_W'(1);
                end
            end
            ST_TICK: begin
                if (!freeze) begin
                    rd_en     = r_rd_on;
                    n_cmp_vld = r_rd_on;
                    n_cmp_idx = r_rd_idx;
                    if (r_rd_on) begin
                        if (r_rd_idx == IDX_LAST) begin
                            n_rd_on = 1'b0;
                        end else begin
                            n_rd_idx = r_rd_idx + IDX_W'(1);
                        end
                    end
                    if (cmp_due) begin
                        if (r_held_vld) begin
                            n_out     = r_held;
                            n_out_vld = 1'b1;
                        end
                        n_held            = fired_word;
                        n_held_vld        = 1'b1;
                        n_occ[r_cmp_idx]  = 1'b0;
                        n_fire_cnt        = r_fire_cnt + FIRE_W'(1);
                    end
                    if (r_cmp_vld && ((r_cmp_idx == IDX_LAST) ||
                            (cmp_due && (r_fire_cnt + FIRE_W'(1) == FIRE_W'(MAX_FIRE))))) begin
                        n_state = ST_FLUSH;
                    end
                end
            end
            ST_FLUSH: begin
                if (can_push) begin
                    n_out      = r_held;
                    n_out.last = 1'b1;
                    n_out_vld  = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_now      <= '0;
            r_occ      <= '0;
            r_rd_on    <= 1'b0;
            r_cmp_vld  <= 1'b0;
            r_held_vld <= 1'b0;
            r_out_vld  <= 1'b0;
            r_fire_cnt <= '0;
        end else begin
            r_state    <= n_state;
            r_now      <= n_now;
            r_occ      <= n_occ;
            r_rd_on    <= n_rd_on;
            r_cmp_vld  <= n_cmp_vld;
            r_held_vld <= n_held_vld;
            r_out_vld  <= n_out_vld;
            r_fire_cnt <= n_fire_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx  <= n_rd_idx;
        r_cmp_idx <= n_cmp_idx;
        r_held    <= n_held;
        r_out     <= n_out;
        r_delay   <= n_delay;
        r_code    <= n_code;
        r_param   <= n_param;
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule

@@ hdl/dtst_store.sv @@
// ----------------------------------------------------------------------------
// dtst_store
// Slot memory: code, deadline and parameter of each slot. One write port,
// one read port with registered read data.
// ----------------------------------------------------------------------------
module dtst_store #(
    parameter int SLOTS = dtst_pkg::DEF_SLOTS
) (
    input  logic                        i_clk,
    input  logic                        i_wr_en,
    input  logic [$clog2(SLOTS)-1:0]    i_wr_idx,
    input  dtst_pkg::t_slot_entry       i_wr_data,
    input  logic                        i_rd_en,
    input  logic [$clog2(SLOTS)-1:0]    i_rd_idx,
    output dtst_pkg::t_slot_entry       o_rd_data
);
    import dtst_pkg::*;

    t_slot_entry r_mem [SLOTS];
    t_slot_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_idx] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_idx];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
